### hdl/dfrsp_pkg.sv
// Package for the DLE frame receiver and sub-packet parser.
// Holds the frame constants, the queue command type and the result type.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package dfrsp_pkg;

    // Frame limits and byte codes.
    localparam int unsigned MAX_FRAME   = 1024;
    localparam int unsigned CNT_W       = $clog2(MAX_FRAME + 1);
    localparam int unsigned FLEN_W      = 11;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] DLE_BYTE  = 8'h10;
    localparam logic [7:0] ETX_BYTE  = 8'h03;
    localparam logic [7:0] ACK_CLASS = 8'h02;

    // Smallest frame that carries a checksum, and the first parsed position
    // expressed as a stored count at release time (offset 2 plus the delay).
    localparam logic [CNT_W-1:0] MIN_FRAME_CNT = CNT_W'(4);
    localparam logic [CNT_W-1:0] PARSE_CNT     = CNT_W'(4);
    localparam logic [CNT_W-1:0] RELEASE_CNT   = CNT_W'(2);
    localparam logic [CNT_W-1:0] CLASS_CNT     = CNT_W'(1);
    localparam logic [CNT_W-1:0] MAX_CNT       = CNT_W'(MAX_FRAME);

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    // Frame status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CSUM_BAD  = 3'd1,
        ST_SHORT     = 3'd2,
        ST_ACK       = 3'd3,
        ST_CUT_OFF   = 3'd4,
        ST_EARLY_END = 3'd5,
        ST_OVERFLOW  = 3'd6
    } status_t;

    // Commands from the framing front end to the parser back end.
    typedef enum logic [1:0] {
        CMD_RELEASE = 2'd0,
        CMD_END     = 2'd1,
        CMD_ABORT   = 2'd2
    } cmd_op_t;

    // Sub-packet parse phase.
    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_LEN_LO  = 2'd1,
        PH_LEN_HI  = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [7:0]        frame_class;
        logic              parse;        // released byte lies at offset 2 or later
        logic [7:0]        data;         // released byte
        logic              short_frame;  // frame end below minimum length
        status_t           abort_code;   // early end or overflow
        logic [FLEN_W-1:0] frame_length;
        logic [15:0]       csum_rx;
    } cmd_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        frame_class;
        logic [7:0]        sub_type;
        logic [15:0]       sub_length;
        logic [15:0]       byte_index;
        logic [7:0]        data_byte;
        logic [2:0]        frame_status;
        logic [FLEN_W-1:0] frame_length;
        logic [15:0]       checksum_received;
        logic [15:0]       checksum_computed;
    } result_t;

endpackage

`default_nettype wire

### hdl/dfrsp_front.sv
// Framing front end: hunts for the start byte, removes DLE escapes and
// keeps the two-byte checksum delay line; emits one command per byte at most.
// Depends on dfrsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfrsp_front
    import dfrsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       queue_full,
    output logic            cmd_push,
    output cmd_t            cmd
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             esc_reg, esc_next;
    logic [7:0]       d0_reg, d0_next;
    logic [7:0]       d1_reg, d1_next;
    logic [7:0]       class_reg, class_next;
    logic             accept;
    logic             has_cmd;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign cmd_push = accept && has_cmd;

    // Per-byte framing decision.
    always_comb
    begin
        cnt_next   = cnt_reg;
        esc_next   = esc_reg;
        d0_next    = d0_reg;
        d1_next    = d1_reg;
        class_next = class_reg;
        has_cmd    = 1'b0;

        cmd              = '0;
        cmd.op           = CMD_RELEASE;
        cmd.frame_class  = class_reg;
        cmd.abort_code   = ST_OK;
        cmd.frame_length = FLEN_W'(cnt_reg);
        cmd.csum_rx      = {d1_reg, d0_reg};
        cmd.data         = d0_reg;
        cmd.parse        = (cnt_reg >= PARSE_CNT);
        cmd.short_frame  = (cnt_reg < MIN_FRAME_CNT);

        if (accept)
        begin
            priority if (cnt_reg == '0)
            begin
                // Hunting for the start byte.
                esc_next = 1'b0;
                if (rx_byte == DLE_BYTE)
                begin
                    d0_next  = d1_reg;
                    d1_next  = rx_byte;
                    cnt_next = CLASS_CNT;
                end
            end
            else if (cnt_reg == CLASS_CNT && rx_byte == ETX_BYTE)
            begin
                // End marker right after the start byte.
                has_cmd        = 1'b1;
                cmd.op         = CMD_ABORT;
                cmd.abort_code = ST_EARLY_END;
                cnt_next       = '0;
                esc_next       = 1'b0;
                d0_next        = '0;
                d1_next        = '0;
                class_next     = '0;
            end
            else if (!esc_reg && rx_byte == DLE_BYTE)
            begin
                esc_next = 1'b1;
            end
            else if (esc_reg && rx_byte == ETX_BYTE)
            begin
                // Frame end: the delay line holds the checksum.
                has_cmd    = 1'b1;
                cmd.op     = CMD_END;
                cnt_next   = '0;
                esc_next   = 1'b0;
                d0_next    = '0;
                d1_next    = '0;
                class_next = '0;
            end
            else if (cnt_reg >= MAX_CNT)
            begin
                // Overflow: drop the frame, this byte opens a new one.
                has_cmd        = 1'b1;
                cmd.op         = CMD_ABORT;
                cmd.abort_code = ST_OVERFLOW;
                esc_next       = 1'b0;
                d0_next        = '0;
                d1_next        = rx_byte;
                class_next     = '0;
                cnt_next       = CLASS_CNT;
            end
            else
            begin
                // Store the byte; the oldest delayed byte is released.
                esc_next = 1'b0;
                if (cnt_reg == CLASS_CNT)
                begin
                    class_next = rx_byte;
                end
                has_cmd  = (cnt_reg >= RELEASE_CNT);
                d0_next  = d1_reg;
                d1_next  = rx_byte;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            esc_reg   <= 1'b0;
            d0_reg    <= '0;
            d1_reg    <= '0;
            class_reg <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            esc_reg   <= esc_next;
            d0_reg    <= d0_next;
            d1_reg    <= d1_next;
            class_reg <= class_next;
        end
    end

    // The stored count never passes the frame limit.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= MAX_CNT)
        else $error("stored count above frame limit");

    // An escape can only be pending inside a frame.
    assert property (@(posedge clk) disable iff (!rst_n) esc_reg |-> (cnt_reg != '0))
        else $error("escape pending while hunting");

endmodule

`default_nettype wire

### hdl/dfrsp_queue.sv
// Two-entry command queue between the framing front end and the parser.
// Lets either side stall without blocking the other until the queue runs full or empty. Depends on dfrsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfrsp_queue
    import dfrsp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    output logic      head_valid,
    output cmd_t      head_cmd,
    input  wire logic pop
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // Pointer and fill update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // No write into a full queue, no read from an empty one.
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("command pushed into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("command popped from empty queue");

endmodule

`default_nettype wire

### hdl/dfrsp_back.sv
// Parser back end: running checksum, sub-packet parse and frame status,
// with a registered result stage. Depends on dfrsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfrsp_back
    import dfrsp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      cmd_pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   result
);

    phase_t      phase_reg, phase_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] pcnt_reg, pcnt_next;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg, res_new;
    logic        produce;
    logic        parse_en;
    logic [15:0] len_full;
    logic [15:0] pcnt_inc;

    assign cmd_pop   = cmd_valid && (!out_valid_reg || out_ready);
    assign parse_en  = cmd.parse && (cmd.frame_class != ACK_CLASS);
    assign len_full  = {cmd.data, len_reg[7:0]};
    assign pcnt_inc  = pcnt_reg + 16'd1;
    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    // Parse phase next state.
    always_comb
    begin
        phase_next = phase_reg;
        if (cmd_pop)
        begin
            unique case (cmd.op)
                CMD_RELEASE:
                begin
                    if (parse_en)
                    begin
                        unique case (phase_reg)
                            PH_TYPE:    phase_next = PH_LEN_LO;
                            PH_LEN_LO:  phase_next = PH_LEN_HI;
                            PH_LEN_HI:  phase_next = (len_full != '0) ? PH_PAYLOAD : PH_TYPE;
                            PH_PAYLOAD: phase_next = (pcnt_inc == len_reg) ? PH_TYPE : PH_PAYLOAD;
                        endcase
                    end
                end
                CMD_END:   phase_next = PH_TYPE;
                CMD_ABORT: phase_next = PH_TYPE;
                default:   phase_next = PH_TYPE;
            endcase
        end
    end

    // Datapath and result forming.
    always_comb
    begin
        sum_next  = sum_reg;
        type_next = type_reg;
        len_next  = len_reg;
        pcnt_next = pcnt_reg;
        produce   = 1'b0;

        res_new             = '0;
        res_new.kind        = KIND_STATUS;
        res_new.frame_class = cmd.frame_class;

        if (cmd_pop)
        begin
            unique case (cmd.op)
                CMD_RELEASE:
                begin
                    sum_next = sum_reg + {8'd0, cmd.data};
                    if (parse_en)
                    begin
                        unique case (phase_reg)
                            PH_TYPE:
                            begin
                                type_next = cmd.data;
                            end
                            PH_LEN_LO:
                            begin
                                len_next = {8'd0, cmd.data};
                            end
                            PH_LEN_HI:
                            begin
                                len_next           = len_full;
                                pcnt_next          = '0;
                                produce            = 1'b1;
                                res_new.kind       = KIND_HEADER;
                                res_new.sub_type   = type_reg;
                                res_new.sub_length = len_full;
                            end
                            PH_PAYLOAD:
                            begin
                                pcnt_next          = pcnt_inc;
                                produce            = 1'b1;
                                res_new.kind       = KIND_PAYLOAD;
                                res_new.sub_type   = type_reg;
                                res_new.sub_length = len_reg;
                                res_new.byte_index = pcnt_reg;
                                res_new.data_byte  = cmd.data;
                            end
                        endcase
                    end
                end
                CMD_END:
                begin
                    produce              = 1'b1;
                    res_new.frame_length = cmd.frame_length;
                    if (cmd.short_frame)
                    begin
                        res_new.frame_status = ST_SHORT;
                    end
                    else
                    begin
                        res_new.checksum_received = cmd.csum_rx;
                        res_new.checksum_computed = sum_reg;
                        priority if (cmd.csum_rx != sum_reg)
                            res_new.frame_status = ST_CSUM_BAD;
                        else if (cmd.frame_class == ACK_CLASS)
                            res_new.frame_status = ST_ACK;
                        else if (phase_reg == PH_PAYLOAD)
                            res_new.frame_status = ST_CUT_OFF;
                        else
                            res_new.frame_status = ST_OK;
                    end
                    sum_next  = '0;
                    type_next = '0;
                    len_next  = '0;
                    pcnt_next = '0;
                end
                CMD_ABORT:
                begin
                    produce              = 1'b1;
                    res_new.frame_length = cmd.frame_length;
                    res_new.frame_status = cmd.abort_code;
                    sum_next             = '0;
                    type_next            = '0;
                    len_next             = '0;
                    pcnt_next            = '0;
                end
                default:
                begin
                    produce = 1'b0;
                end
            endcase
        end

        // Output stage: drain on take, load on a new result.
        out_valid_next = out_valid_reg && !out_ready;
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TYPE;
            sum_reg       <= '0;
            type_reg      <= '0;
            len_reg       <= '0;
            pcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            pcnt_reg      <= pcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            res_reg <= res_new;
        end
    end

    // A payload phase always has a nonzero length and a count below it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (len_reg != '0 && pcnt_reg < len_reg))
        else $error("payload phase with bad length or count");

    // A waiting result holds while the consumer stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd_pop)
        else $error("command taken while result stalled");

endmodule

`default_nettype wire

### hdl/dle_frame_receiver_subpacket_parser.sv
// Top level of the DLE frame receiver and sub-packet parser.
// Depends on dfrsp_pkg, dfrsp_front, dfrsp_queue and dfrsp_back.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+-------------------------------------------
//   input    | in_valid / in_ready  | rx_byte
//   output   | out_valid / out_ready| kind, frame_class, sub_type, sub_length,
//            |                      | byte_index, data_byte, frame_status,
//            |                      | frame_length, checksum_received/computed
//
// One byte is accepted per cycle while in_ready is high; the command it yields, if any,
// is held in the command queue and its result in the parser's output register.
// in_ready drops only when the two-entry command queue is full.
// The parser takes one queued command per cycle while its output register is
// empty or being taken.
// Reset (rst_n, asynchronous, active low) returns to hunting for a start byte.
`timescale 1ns / 1ps
`default_nettype none

module dle_frame_receiver_subpacket_parser
    import dfrsp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        rx_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             kind,
    output logic [7:0]             frame_class,
    output logic [7:0]             sub_type,
    output logic [15:0]            sub_length,
    output logic [15:0]            byte_index,
    output logic [7:0]             data_byte,
    output logic [2:0]             frame_status,
    output logic [FLEN_W-1:0]      frame_length,
    output logic [15:0]            checksum_received,
    output logic [15:0]            checksum_computed
);

    cmd_t    push_cmd;
    cmd_t    head_cmd;
    logic    cmd_push;
    logic    queue_full;
    logic    head_valid;
    logic    cmd_pop;
    result_t result;

    // Framing front end.
    dfrsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .cmd_push   (cmd_push),
        .cmd        (push_cmd)
    );

    // Command queue.
    dfrsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (cmd_pop)
    );

    // Parser back end.
    dfrsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    // Result fields onto the ports.
    assign kind              = result.kind;
    assign frame_class       = result.frame_class;
    assign sub_type          = result.sub_type;
    assign sub_length        = result.sub_length;
    assign byte_index        = result.byte_index;
    assign data_byte         = result.data_byte;
    assign frame_status      = result.frame_status;
    assign frame_length      = result.frame_length;
    assign checksum_received = result.checksum_received;
    assign checksum_computed = result.checksum_computed;

endmodule

`default_nettype wire
